FILE: rtl/core/ethernet_arp_responder_unit_assert.svh
// Assertion macros shared by the ARP responder modules.
`ifndef ETHERNET_ARP_RESPONDER_UNIT_ASSERT_SVH
`define ETHERNET_ARP_RESPONDER_UNIT_ASSERT_SVH

// Same-cycle implication under a synchronous active-low reset.
`define EAR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ARP responder assertion failed");

// Next-cycle implication under a synchronous active-low reset.
`define EAR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ARP responder assertion failed");

`endif

FILE: rtl/core/ear_pkg.sv
// Shared types, constants and the reply byte function of the ARP responder.
package ear_pkg;

    // Sizing defaults
    localparam int unsigned MAX_FRAME_BYTES_DEF = 2048;
    localparam int unsigned QUEUE_DEPTH_DEF     = 4;

    // Frame layout
    localparam int unsigned MAC_HDR_LEN = 14;
    localparam int unsigned ARP_MIN_LEN = 42;
    localparam int unsigned POS_SRC_LO  = 6;
    localparam int unsigned POS_SRC_HI  = 12;
    localparam int unsigned POS_TYPE_HI = 13;
    localparam int unsigned POS_OP_LO   = 20;
    localparam int unsigned POS_OP_HI   = 21;
    localparam int unsigned POS_SHA_LO  = 22;
    localparam int unsigned POS_SHA_HI  = 28;
    localparam int unsigned POS_SPA_HI  = 32;
    localparam int unsigned POS_TPA_LO  = 38;
    localparam int unsigned POS_TPA_HI  = 42;

    // Protocol codes
    localparam logic [15:0] TYPE_ARP       = 16'h0806;
    localparam logic [15:0] TYPE_IPV4      = 16'h0800;
    localparam logic [15:0] ARP_HRD_ETHER  = 16'h0001;
    localparam logic [15:0] ARP_OP_REQUEST = 16'h0001;
    localparam logic [15:0] ARP_OP_REPLY   = 16'h0002;
    localparam logic [7:0]  ARP_HLN        = 8'd6;
    localparam logic [7:0]  ARP_PLN        = 8'd4;

    localparam logic [47:0] CLIENT_MAC_RST = 48'h5254_0012_3456;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 40;

    localparam logic [23:0] SUBNET_RST    = 24'd655362;
    localparam logic [7:0]  ALIAS_RST     = 8'd2;
    localparam logic [7:0]  DNS_FIRST_RST = 8'd3;
    localparam logic [2:0]  DNS_COUNT_RST = 3'd1;
    localparam logic [39:0] GW_MAC_RST    = 40'd353596609077;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUBNET    = 3'd0,
        CFG_ALIAS     = 3'd1,
        CFG_DNS_FIRST = 3'd2,
        CFG_DNS_COUNT = 3'd3,
        CFG_GW_MAC    = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        KIND_REPLY   = 1'b0,
        KIND_PAYLOAD = 1'b1
    } t_out_kind;

    typedef struct packed {
        logic [23:0] subnet_prefix;
        logic [7:0]  alias_octet;
        logic [7:0]  dns_first_octet;
        logic [2:0]  dns_octet_count;
        logic [39:0] gw_mac_prefix;
    } t_cfg;

    // One queued job: a payload byte or a whole reply
    typedef struct packed {
        t_out_kind   kind;
        logic [7:0]  data;
        logic        last;
        logic [47:0] mac;        // learned MAC; for a reply also its destination
        logic [47:0] sender_mac;
        logic [31:0] sender_ip;
        logic [31:0] target_ip;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // Byte idx of the 42-byte reply frame built from a queued job
    function automatic logic [7:0] reply_byte(input logic [5:0] idx, input t_cmd cmd,
                                              input logic [39:0] gw);
        logic [47:0] src;
        logic [ARP_MIN_LEN*8-1:0] frame;
        logic [5:0] k;
        src   = {gw, cmd.target_ip[7:0]};
        frame = {cmd.mac, src, TYPE_ARP, ARP_HRD_ETHER, TYPE_IPV4, ARP_HLN, ARP_PLN,
                 ARP_OP_REPLY, src, cmd.target_ip, cmd.sender_mac, cmd.sender_ip};
        k     = 6'(ARP_MIN_LEN - 1) - idx;
        if (idx < 6'(ARP_MIN_LEN)) begin
            return frame[k*8 +: 8];
        end
        return 8'h00;
    endfunction

endpackage

FILE: rtl/core/ear_ifs.sv
// Stream interfaces for frame bytes in and result bytes out.
interface ear_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

interface ear_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  out_byte;
    logic        out_kind;
    logic        out_last;
    logic [47:0] learned_mac;

    modport source (output valid, out_byte, out_kind, out_last, learned_mac, input ready);
    modport sink   (input valid, out_byte, out_kind, out_last, learned_mac, output ready);
endinterface

FILE: rtl/core/ethernet_arp_responder_unit.sv
// Top level of the ARP reply offload with IPv4 payload pass-through.
//
//  channel | dir | beat payload                                   | handshake
//  --------+-----+------------------------------------------------+-------------
//  i_in    | in  | frame_byte[7:0], frame_last                    | valid/ready
//  o_out   | out | out_byte[7:0], out_kind, out_last, learned_mac | valid/ready
//  i_cfg_* | in  | i_cfg_idx[2:0], i_cfg_data[39:0]               | i_cfg_we only
//
// The parser takes one frame byte per cycle while the job queue has room.
// An IPv4 payload beat passes the job queue and the output register; a reply
// streams 42 beats, one per cycle while o_out is ready.
// The job queue (QUEUE_DEPTH entries) lets the parser run on while a reply
// drains; the parser stalls only when the queue is full.
// Reset is synchronous and active low; it restores the register defaults.

module ethernet_arp_responder_unit #(
    parameter int unsigned MAX_FRAME_BYTES = ear_pkg::MAX_FRAME_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH     = ear_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ear_in_if.sink                         i_in,
    ear_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [ear_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ear_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    ear_pkg::t_cfg      r_cfg;
    ear_pkg::t_cmd      push_cmd;
    ear_pkg::t_cmd      head_cmd;
    ear_pkg::t_q_status q_status;
    logic               push;
    logic               pop;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.subnet_prefix   <= ear_pkg::SUBNET_RST;
            r_cfg.alias_octet     <= ear_pkg::ALIAS_RST;
            r_cfg.dns_first_octet <= ear_pkg::DNS_FIRST_RST;
            r_cfg.dns_octet_count <= ear_pkg::DNS_COUNT_RST;
            r_cfg.gw_mac_prefix   <= ear_pkg::GW_MAC_RST;
        end else if (i_cfg_we) begin
            case (ear_pkg::t_cfg_idx'(i_cfg_idx))
                ear_pkg::CFG_SUBNET:    r_cfg.subnet_prefix   <= i_cfg_data[23:0];
                ear_pkg::CFG_ALIAS:     r_cfg.alias_octet     <= i_cfg_data[7:0];
                ear_pkg::CFG_DNS_FIRST: r_cfg.dns_first_octet <= i_cfg_data[7:0];
                ear_pkg::CFG_DNS_COUNT: r_cfg.dns_octet_count <= i_cfg_data[2:0];
                ear_pkg::CFG_GW_MAC:    r_cfg.gw_mac_prefix   <= i_cfg_data[39:0];
                default: begin
                end
            endcase
        end
    end

    ear_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (r_cfg),
        .i_q     (q_status),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    ear_cmd_fifo #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (push_cmd),
        .i_pop    (pop),
        .o_head   (head_cmd),
        .o_status (q_status)
    );

    ear_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head_cmd),
        .i_q             (q_status),
        .i_gw_mac_prefix (r_cfg.gw_mac_prefix),
        .o_pop           (pop),
        .o_out           (o_out)
    );

endmodule

FILE: rtl/core/ear_front.sv
// Frame parser: captures header fields, classifies each beat and queues jobs.
`include "ethernet_arp_responder_unit_assert.svh"

module ear_front #(
    parameter int unsigned MAX_FRAME_BYTES = ear_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ear_in_if.sink            i_in,
    input  ear_pkg::t_cfg     i_cfg,
    input  ear_pkg::t_q_status i_q,
    output logic              o_push,
    output ear_pkg::t_cmd     o_cmd
);

    localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

    logic [POS_W-1:0] r_pos,        n_pos;
    logic [15:0]      r_type,       n_type;
    logic [15:0]      r_opcode,     n_opcode;
    logic [47:0]      r_src_mac,    n_src_mac;
    logic [47:0]      r_snd_mac,    n_snd_mac;
    logic [31:0]      r_snd_ip,     n_snd_ip;
    logic [31:0]      r_tgt_ip,     n_tgt_ip;
    logic [47:0]      r_client_mac, n_client_mac;

    logic       acc;
    logic       in_range;
    logic [7:0] b;
    logic [7:0] host;
    logic [8:0] dns_end;
    logic       tgt_match;
    logic       reply_hit;
    logic       payload_hit;

    assign i_in.ready = !i_q.full;
    assign acc        = i_in.valid && i_in.ready;
    assign b          = i_in.frame_byte;
    assign in_range   = r_pos < POS_MAX;

    // Capture header fields at their byte positions
    always_comb begin
        n_type    = r_type;
        n_opcode  = r_opcode;
        n_src_mac = r_src_mac;
        n_snd_mac = r_snd_mac;
        n_snd_ip  = r_snd_ip;
        n_tgt_ip  = r_tgt_ip;
        if (in_range) begin
            if (r_pos >= POS_W'(ear_pkg::POS_SRC_LO) && r_pos < POS_W'(ear_pkg::POS_SRC_HI)) begin
                n_src_mac = {r_src_mac[39:0], b};
            end else if (r_pos >= POS_W'(ear_pkg::POS_SRC_HI)
                         && r_pos <= POS_W'(ear_pkg::POS_TYPE_HI)) begin
                n_type = {r_type[7:0], b};
            end else if (r_pos >= POS_W'(ear_pkg::POS_OP_LO)
                         && r_pos <= POS_W'(ear_pkg::POS_OP_HI)) begin
                n_opcode = {r_opcode[7:0], b};
            end else if (r_pos >= POS_W'(ear_pkg::POS_SHA_LO)
                         && r_pos < POS_W'(ear_pkg::POS_SHA_HI)) begin
                n_snd_mac = {r_snd_mac[39:0], b};
            end else if (r_pos >= POS_W'(ear_pkg::POS_SHA_HI)
                         && r_pos < POS_W'(ear_pkg::POS_SPA_HI)) begin
                n_snd_ip = {r_snd_ip[23:0], b};
            end else if (r_pos >= POS_W'(ear_pkg::POS_TPA_LO)
                         && r_pos < POS_W'(ear_pkg::POS_TPA_HI)) begin
                n_tgt_ip = {r_tgt_ip[23:0], b};
            end
        end
    end

    // Decide on the target address: subnet plus alias or DNS host range
    assign host      = n_tgt_ip[7:0];
    assign dns_end   = {1'b0, i_cfg.dns_first_octet} + 9'(i_cfg.dns_octet_count);
    assign tgt_match = (n_tgt_ip[31:8] == i_cfg.subnet_prefix)
                       && ((host == i_cfg.alias_octet)
                           || (host >= i_cfg.dns_first_octet && {1'b0, host} < dns_end));

    assign reply_hit   = i_in.frame_last && (n_type == ear_pkg::TYPE_ARP)
                         && (r_pos >= POS_W'(ear_pkg::ARP_MIN_LEN - 1))
                         && (n_opcode == ear_pkg::ARP_OP_REQUEST) && tgt_match;
    assign payload_hit = in_range && (r_pos >= POS_W'(ear_pkg::MAC_HDR_LEN))
                         && (r_type == ear_pkg::TYPE_IPV4);

    // Advance position; clear per-frame state at frame end
    always_comb begin
        n_pos        = r_pos;
        n_client_mac = r_client_mac;
        if (reply_hit) begin
            n_client_mac = n_src_mac;
        end
        if (i_in.frame_last) begin
            n_pos = '0;
        end else if (in_range) begin
            n_pos = r_pos + 1'b1;
        end
    end

    // Build the queued job
    always_comb begin
        o_push            = acc && (reply_hit || payload_hit);
        o_cmd.kind        = reply_hit ? ear_pkg::KIND_REPLY : ear_pkg::KIND_PAYLOAD;
        o_cmd.data        = b;
        o_cmd.last        = i_in.frame_last;
        o_cmd.mac         = reply_hit ? n_src_mac : r_client_mac;
        o_cmd.sender_mac  = n_snd_mac;
        o_cmd.sender_ip   = n_snd_ip;
        o_cmd.target_ip   = n_tgt_ip;
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos        <= '0;
            r_type       <= '0;
            r_opcode     <= '0;
            r_client_mac <= ear_pkg::CLIENT_MAC_RST;
        end else if (acc) begin
            r_pos        <= n_pos;
            r_client_mac <= n_client_mac;
            r_type       <= i_in.frame_last ? 16'h0000 : n_type;
            r_opcode     <= i_in.frame_last ? 16'h0000 : n_opcode;
        end
    end

    // Hold captured addresses
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_src_mac <= n_src_mac;
            r_snd_mac <= n_snd_mac;
            r_snd_ip  <= n_snd_ip;
            r_tgt_ip  <= n_tgt_ip;
        end
    end

    `EAR_ASSERT_NXT(a_frame_end_rewinds, i_clk, i_rst_n, acc && i_in.frame_last, r_pos == '0)

endmodule

FILE: rtl/core/ear_cmd_fifo.sv
// Job queue between the frame parser and the result emitter.
`include "ethernet_arp_responder_unit_assert.svh"

module ear_cmd_fifo #(
    parameter int unsigned DEPTH = ear_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  ear_pkg::t_cmd      i_cmd,
    input  logic               i_pop,
    output ear_pkg::t_cmd      o_head,
    output ear_pkg::t_q_status o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    ear_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_status.full  = r_count == CNT_W'(DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_head         = r_mem[r_rd];

    // Advance pointers and occupancy
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    `EAR_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_status.full)
    `EAR_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_status.empty)
    `EAR_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

FILE: rtl/core/ear_back.sv
// Result emitter: expands queued jobs into output beats behind an output register.
`include "ethernet_arp_responder_unit_assert.svh"

module ear_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ear_pkg::t_cmd      i_head,
    input  ear_pkg::t_q_status i_q,
    input  logic [39:0]        i_gw_mac_prefix,
    output logic               o_pop,
    ear_out_if.source          o_out
);

    logic [5:0]         r_idx, n_idx;
    logic               r_valid;
    logic [7:0]         r_byte;
    ear_pkg::t_out_kind r_kind;
    logic               r_last;
    logic [47:0]        r_mac;

    logic load;
    logic is_reply;
    logic reply_end;

    assign load      = !i_q.empty && (!r_valid || o_out.ready);
    assign is_reply  = i_head.kind == ear_pkg::KIND_REPLY;
    assign reply_end = r_idx == 6'(ear_pkg::ARP_MIN_LEN - 1);
    assign o_pop     = load && (!is_reply || reply_end);

    // Step through reply bytes
    always_comb begin
        n_idx = r_idx;
        if (load && is_reply) begin
            n_idx = reply_end ? 6'd0 : r_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= is_reply ? ear_pkg::reply_byte(r_idx, i_head, i_gw_mac_prefix)
                               : i_head.data;
            r_kind <= i_head.kind;
            r_last <= is_reply ? reply_end : i_head.last;
            r_mac  <= i_head.mac;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.out_kind    = r_kind;
    assign o_out.out_last    = r_last;
    assign o_out.learned_mac = r_mac;

    `EAR_ASSERT_IMP(a_mid_reply_head, i_clk, i_rst_n, r_idx != 6'd0, !i_q.empty && is_reply)

endmodule

FILE: tb/sv/ethernet_arp_responder_unit_test.sv
`timescale 1ns / 100ps
// Self-checking bench for the ARP responder: directed frames, then random frames per setting.
module ethernet_arp_responder_unit_test;

    localparam int unsigned MAX_BYTES   = ear_pkg::MAX_FRAME_BYTES_DEF;
    localparam int          DRAIN_SLACK = 48;
    localparam int          SHOW_LIMIT  = 10;
    localparam int          N_ROWS      = 18;
    localparam int          N_PHASES    = 8;
    localparam int          PHASE_FRAMES = 6;

    typedef enum {FR_IPV4, FR_ARP, FR_OTHER, FR_NOISE} t_form;
    typedef enum {HOST_ALIAS, HOST_DNS_FIRST, HOST_DNS_IN, HOST_DNS_END, HOST_RAND} t_host_pick;

    typedef struct {
        t_form       form;
        int          len;
        logic [15:0] op;
        t_host_pick  host;
        bit          in_subnet;
        int          beats;      // typed beat count, -1 leaves it to the tracker
    } t_row;

    typedef struct {
        logic [7:0]         data;
        ear_pkg::t_out_kind kind;
        logic               last;
        logic [47:0]        mac;
    } t_beat;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [ear_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [ear_pkg::CFG_DATA_W-1:0] i_cfg_data;

    ear_in_if  in_if ();
    ear_out_if out_if ();

    ethernet_arp_responder_unit #(
        .MAX_FRAME_BYTES(MAX_BYTES)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Frame parser tracker: its own copy of settings and captured fields
    ear_pkg::t_cfg cfg_m;
    int unsigned   pos_m;
    logic [15:0]   type_m;
    logic [15:0]   op_m;
    logic [47:0]   src_m;
    logic [47:0]   sha_m;
    logic [47:0]   client_m;
    logic [31:0]   spa_m;
    logic [31:0]   tpa_m;
    t_beat         due_beats [$];

    logic [7:0]  frame_q [$];
    int          snd_idle_pct  = 0;
    int          rcv_stall_pct = 0;
    int          err_count     = 0;
    int          rx_count      = 0;

    t_row directed_frames [N_ROWS] = '{
        '{FR_IPV4,  20, 16'h0000,               HOST_RAND,      1'b1, 6},
        '{FR_NOISE, 1,  16'h0000,               HOST_RAND,      1'b1, 0},
        '{FR_IPV4,  13, 16'h0000,               HOST_RAND,      1'b1, 0},
        '{FR_IPV4,  14, 16'h0000,               HOST_RAND,      1'b1, 0},
        '{FR_IPV4,  15, 16'h0000,               HOST_RAND,      1'b1, 1},
        '{FR_ARP,   42, ear_pkg::ARP_OP_REQUEST, HOST_ALIAS,     1'b1, 42},
        '{FR_ARP,   41, ear_pkg::ARP_OP_REQUEST, HOST_ALIAS,     1'b1, 0},
        '{FR_ARP,   60, ear_pkg::ARP_OP_REQUEST, HOST_DNS_FIRST, 1'b1, 42},
        '{FR_ARP,   42, ear_pkg::ARP_OP_REPLY,   HOST_ALIAS,     1'b1, 0},
        '{FR_ARP,   42, ear_pkg::ARP_OP_REQUEST, HOST_ALIAS,     1'b0, 0},
        '{FR_ARP,   42, ear_pkg::ARP_OP_REQUEST, HOST_DNS_END,   1'b1, 0},
        '{FR_ARP,   42, 16'h0101,               HOST_ALIAS,     1'b1, 0},
        '{FR_ARP,   13, ear_pkg::ARP_OP_REQUEST, HOST_ALIAS,     1'b1, 0},
        '{FR_OTHER, 60, ear_pkg::ARP_OP_REQUEST, HOST_ALIAS,     1'b1, 0},
        '{FR_IPV4,  MAX_BYTES + 2, 16'h0000, HOST_RAND, 1'b1,
          MAX_BYTES - ear_pkg::MAC_HDR_LEN},
        '{FR_ARP,   MAX_BYTES + 52, ear_pkg::ARP_OP_REQUEST, HOST_ALIAS, 1'b1, 42},
        '{FR_IPV4,  64, 16'h0000,               HOST_RAND,      1'b1, -1},
        '{FR_ARP,   48, ear_pkg::ARP_OP_REQUEST, HOST_RAND,      1'b1, -1}
    };

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_error(input string what);
        err_count++;
        if (err_count <= SHOW_LIMIT) begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    task automatic reset_tracker();
        cfg_m    = '{ear_pkg::SUBNET_RST, ear_pkg::ALIAS_RST, ear_pkg::DNS_FIRST_RST,
                     ear_pkg::DNS_COUNT_RST, ear_pkg::GW_MAC_RST};
        pos_m    = 0;
        type_m   = '0;
        op_m     = '0;
        src_m    = '0;
        sha_m    = '0;
        spa_m    = '0;
        tpa_m    = '0;
        client_m = ear_pkg::CLIENT_MAC_RST;
        due_beats.delete();
    endtask

    task automatic queue_beat(input logic [7:0] data, input ear_pkg::t_out_kind kind,
                              input logic last);
        t_beat b;
        b.data = data;
        b.kind = kind;
        b.last = last;
        b.mac  = client_m;
        due_beats.push_back(b);
    endtask

    // Target must sit in the subnet and hit the alias or the unwrapped DNS range
    function automatic bit host_answered();
        int h;
        int lo;
        h  = tpa_m[7:0];
        lo = cfg_m.dns_first_octet;
        if (tpa_m[31:8] != cfg_m.subnet_prefix) return 1'b0;
        if (tpa_m[7:0] == cfg_m.alias_octet) return 1'b1;
        return (h >= lo) && (h < lo + int'(cfg_m.dns_octet_count));
    endfunction

    // Lay out the 42-byte reply and queue its beats
    task automatic queue_reply();
        logic [7:0]  rep [ear_pkg::ARP_MIN_LEN];
        logic [47:0] gw_src;
        int          i;
        gw_src = {cfg_m.gw_mac_prefix, tpa_m[7:0]};
        for (i = 0; i < 6; i++) begin
            rep[i]      = src_m[47-8*i -: 8];
            rep[6 + i]  = gw_src[47-8*i -: 8];
            rep[22 + i] = gw_src[47-8*i -: 8];
            rep[32 + i] = sha_m[47-8*i -: 8];
        end
        for (i = 0; i < 4; i++) begin
            rep[28 + i] = tpa_m[31-8*i -: 8];
            rep[38 + i] = spa_m[31-8*i -: 8];
        end
        rep[12] = ear_pkg::TYPE_ARP[15:8];
        rep[13] = ear_pkg::TYPE_ARP[7:0];
        rep[14] = ear_pkg::ARP_HRD_ETHER[15:8];
        rep[15] = ear_pkg::ARP_HRD_ETHER[7:0];
        rep[16] = ear_pkg::TYPE_IPV4[15:8];
        rep[17] = ear_pkg::TYPE_IPV4[7:0];
        rep[18] = ear_pkg::ARP_HLN;
        rep[19] = ear_pkg::ARP_PLN;
        rep[20] = ear_pkg::ARP_OP_REPLY[15:8];
        rep[21] = ear_pkg::ARP_OP_REPLY[7:0];
        for (i = 0; i < ear_pkg::ARP_MIN_LEN; i++) begin
            queue_beat(rep[i], ear_pkg::KIND_REPLY, i == ear_pkg::ARP_MIN_LEN - 1);
        end
    endtask

    // Advance the tracker by one accepted frame byte
    task automatic advance_parser(input logic [7:0] b, input logic last);
        int unsigned p;
        p = pos_m;
        if (p < MAX_BYTES) begin
            if (p >= ear_pkg::POS_SRC_LO && p < ear_pkg::POS_SRC_HI) begin
                src_m = {src_m[39:0], b};
            end else if (p == ear_pkg::POS_TYPE_HI - 1 || p == ear_pkg::POS_TYPE_HI) begin
                type_m = {type_m[7:0], b};
            end else if (p == ear_pkg::POS_OP_LO || p == ear_pkg::POS_OP_HI) begin
                op_m = {op_m[7:0], b};
            end else if (p >= ear_pkg::POS_SHA_LO && p < ear_pkg::POS_SHA_HI) begin
                sha_m = {sha_m[39:0], b};
            end else if (p >= ear_pkg::POS_SHA_HI && p < ear_pkg::POS_SPA_HI) begin
                spa_m = {spa_m[23:0], b};
            end else if (p >= ear_pkg::POS_TPA_LO && p < ear_pkg::POS_TPA_HI) begin
                tpa_m = {tpa_m[23:0], b};
            end
            if (p >= ear_pkg::MAC_HDR_LEN && type_m == ear_pkg::TYPE_IPV4) begin
                queue_beat(b, ear_pkg::KIND_PAYLOAD, last);
            end
        end
        if (last) begin
            if (type_m == ear_pkg::TYPE_ARP && p + 1 >= ear_pkg::ARP_MIN_LEN &&
                op_m == ear_pkg::ARP_OP_REQUEST && host_answered()) begin
                client_m = src_m;
                queue_reply();
            end
            pos_m  = 0;
            type_m = '0;
            op_m   = '0;
        end else if (p < MAX_BYTES) begin
            pos_m = p + 1;
        end
    endtask

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin : watch_out
        t_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            rx_count++;
            if (due_beats.size() == 0) begin
                report_error($sformatf("unexpected beat: byte %02h kind %0d last %0b mac %012h",
                    out_if.out_byte, out_if.out_kind, out_if.out_last, out_if.learned_mac));
            end else begin
                want = due_beats.pop_front();
                if (out_if.out_byte !== want.data || out_if.out_kind !== want.kind ||
                    out_if.out_last !== want.last || out_if.learned_mac !== want.mac) begin
                    report_error($sformatf(
                        "beat %0d: expected %02h/%0d/%0b/%012h, got %02h/%0d/%0b/%012h",
                        rx_count, want.data, want.kind, want.last, want.mac,
                        out_if.out_byte, out_if.out_kind, out_if.out_last,
                        out_if.learned_mac));
                end
            end
        end
    end

    // Stall the result side at random
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    task automatic set_idling(input int mode);
        case (mode)
            0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin snd_idle_pct = 65; rcv_stall_pct = 0;  end
            2: begin snd_idle_pct = 0;  rcv_stall_pct = 65; end
            default: begin snd_idle_pct = 14; rcv_stall_pct = 14; end
        endcase
    endtask

    // Drive one frame beat, hold it until taken, then track it
    task automatic send_beat(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.frame_byte <= b;
        in_if.frame_last <= last;
        do @(posedge i_clk); while (!in_if.ready);
        advance_parser(b, last);
    endtask

    task automatic send_frame();
        int i;
        for (i = 0; i < frame_q.size(); i++) begin
            send_beat(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    // Drop valid and hold until every expected beat is out
    task automatic wait_drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (due_beats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic cfg_write(input ear_pkg::t_cfg_idx idx,
                             input logic [ear_pkg::CFG_DATA_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        case (idx)
            ear_pkg::CFG_SUBNET:    cfg_m.subnet_prefix   = value[23:0];
            ear_pkg::CFG_ALIAS:     cfg_m.alias_octet     = value[7:0];
            ear_pkg::CFG_DNS_FIRST: cfg_m.dns_first_octet = value[7:0];
            ear_pkg::CFG_DNS_COUNT: cfg_m.dns_octet_count = value[2:0];
            ear_pkg::CFG_GW_MAC:    cfg_m.gw_mac_prefix   = value[39:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input ear_pkg::t_cfg c);
        cfg_write(ear_pkg::CFG_SUBNET,    ear_pkg::CFG_DATA_W'(c.subnet_prefix));
        cfg_write(ear_pkg::CFG_ALIAS,     ear_pkg::CFG_DATA_W'(c.alias_octet));
        cfg_write(ear_pkg::CFG_DNS_FIRST, ear_pkg::CFG_DATA_W'(c.dns_first_octet));
        cfg_write(ear_pkg::CFG_DNS_COUNT, ear_pkg::CFG_DATA_W'(c.dns_octet_count));
        cfg_write(ear_pkg::CFG_GW_MAC,    ear_pkg::CFG_DATA_W'(c.gw_mac_prefix));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_target(input t_host_pick pick, input bit in_subnet);
        logic [23:0] net;
        logic [7:0]  h;
        net = in_subnet ? cfg_m.subnet_prefix
                        : cfg_m.subnet_prefix ^ 24'($urandom_range(1, 24'hFFFFFF));
        case (pick)
            HOST_ALIAS:     h = cfg_m.alias_octet;
            HOST_DNS_FIRST: h = cfg_m.dns_first_octet;
            HOST_DNS_IN:    h = 8'(cfg_m.dns_first_octet +
                                   $urandom_range(0, cfg_m.dns_octet_count));
            HOST_DNS_END:   h = 8'(cfg_m.dns_first_octet + cfg_m.dns_octet_count);
            default:        h = 8'($urandom_range(0, 255));
        endcase
        return {net, h};
    endfunction

    // Fill the frame with random bytes, then place type, opcode and target IP
    task automatic build_frame(input t_form form, input int len, input logic [15:0] op,
                               input logic [31:0] tpa);
        logic [15:0] etype;
        logic [7:0]  b;
        int          i;
        if (form == FR_IPV4) etype = ear_pkg::TYPE_IPV4;
        else if (form == FR_ARP) etype = ear_pkg::TYPE_ARP;
        else etype = 16'($urandom);
        if (form == FR_OTHER &&
            (etype == ear_pkg::TYPE_IPV4 || etype == ear_pkg::TYPE_ARP)) begin
            etype[0] = ~etype[0];
        end
        frame_q.delete();
        for (i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (form != FR_NOISE) begin
                if (i == ear_pkg::POS_TYPE_HI - 1) b = etype[15:8];
                if (i == ear_pkg::POS_TYPE_HI)     b = etype[7:0];
            end
            if (form == FR_ARP) begin
                if (i == ear_pkg::POS_OP_LO) b = op[15:8];
                if (i == ear_pkg::POS_OP_HI) b = op[7:0];
                if (i >= ear_pkg::POS_TPA_LO && i < ear_pkg::POS_TPA_HI) begin
                    b = tpa[8*(ear_pkg::POS_TPA_HI-1-i) +: 8];
                end
            end
            frame_q.push_back(b);
        end
    endtask

    // Mostly well-formed requests and IPv4 frames, some broken ones and noise
    task automatic make_random_frame();
        int         r;
        t_host_pick pick;
        r    = $urandom_range(0, 99);
        pick = t_host_pick'($urandom_range(0, 4));
        if (r < 45) begin
            build_frame(FR_ARP,
                ($urandom_range(0, 9) == 0) ? ear_pkg::ARP_MIN_LEN
                                            : $urandom_range(ear_pkg::ARP_MIN_LEN, 64),
                ear_pkg::ARP_OP_REQUEST, pick_target(pick, $urandom_range(0, 9) != 0));
        end else if (r < 75) begin
            build_frame(FR_IPV4, $urandom_range(ear_pkg::MAC_HDR_LEN, 64), 16'h0000, 32'h0);
        end else if (r < 80) begin
            build_frame(FR_ARP, $urandom_range(ear_pkg::MAC_HDR_LEN, ear_pkg::ARP_MIN_LEN - 1),
                        ear_pkg::ARP_OP_REQUEST, pick_target(HOST_ALIAS, 1'b1));
        end else if (r < 85) begin
            build_frame(FR_ARP, $urandom_range(ear_pkg::ARP_MIN_LEN, 64), 16'($urandom),
                        pick_target(pick, 1'b1));
        end else if (r < 95) begin
            build_frame(FR_OTHER, $urandom_range(ear_pkg::MAC_HDR_LEN, 64),
                        ear_pkg::ARP_OP_REQUEST, pick_target(pick, 1'b1));
        end else begin
            build_frame(FR_NOISE, $urandom_range(1, ear_pkg::MAC_HDR_LEN - 1), 16'h0000,
                        32'h0);
        end
    endtask

    initial begin : run
        int            row;
        int            seen;
        int            ph;
        ear_pkg::t_cfg setting;

        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= ear_pkg::CFG_SUBNET;
        i_cfg_data       <= '0;
        in_if.valid      <= 1'b0;
        in_if.frame_byte <= '0;
        in_if.frame_last <= 1'b0;
        reset_tracker();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under the reset settings
        set_idling(0);
        for (row = 0; row < N_ROWS; row++) begin
            seen = rx_count;
            build_frame(directed_frames[row].form, directed_frames[row].len,
                        directed_frames[row].op,
                        pick_target(directed_frames[row].host, directed_frames[row].in_subnet));
            send_frame();
            wait_drain();
            if (directed_frames[row].beats >= 0 &&
                rx_count - seen != directed_frames[row].beats) begin
                report_error($sformatf("frame %0d: expected %0d beats, got %0d", row,
                    directed_frames[row].beats, rx_count - seen));
            end
        end

        // Random frames, one setting and one idling mode per phase
        for (ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0: setting = '{24'h0, 8'h00, 8'h00, 3'd0, 40'h0};
                1: setting = '{24'hFF_FFFF, 8'hFF, 8'hFF, 3'd4, 40'hFF_FFFF_FFFF};
                2: setting = '{24'($urandom), 8'($urandom), 8'd252, 3'd7,
                               {8'($urandom), 32'($urandom)}};
                default: setting = '{24'($urandom), 8'($urandom), 8'($urandom),
                                     3'($urandom_range(0, 7)), {8'($urandom), 32'($urandom)}};
            endcase
            wait_drain();
            load_settings(setting);
            set_idling(ph % 4);
            repeat (PHASE_FRAMES) begin
                make_random_frame();
                send_frame();
            end
        end

        wait_drain();
        repeat (DRAIN_SLACK) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Give up on a hung run
    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
